// ===== rtl/ubds_pkg.sv =====
package ubds_pkg;

   localparam int unsigned DivW = 48;
   localparam int unsigned DsrW = 32;

   localparam logic [31:0] INC_MAX = 32'd65535;
   localparam logic [31:0] NUM_MAX = INC_MAX * 32'd7;
   localparam logic [31:0] TOL_DIV = 32'd100;
   localparam logic [31:0] CLK_RESET = 32'd80000000;

   localparam logic [2:0] CODE_DIV1 = 3'h5;
   localparam logic [2:0] CODE_DIV2 = 3'h4;
   localparam logic [2:0] CODE_DIV3 = 3'h3;
   localparam logic [2:0] CODE_DIV4 = 3'h2;
   localparam logic [2:0] CODE_DIV5 = 3'h1;
   localparam logic [2:0] CODE_DIV6 = 3'h0;
   localparam logic [2:0] CODE_DIV7 = 3'h6;

   typedef enum logic [4:0] {
      ST_IDLE, ST_GCD1, ST_NUM, ST_DEN, ST_M, ST_N, ST_SNUM, ST_SDEN,
      ST_DIVR, ST_GCD2, ST_TN, ST_TD, ST_MUL, ST_ACH, ST_TOL, ST_MOD,
      ST_FINISH, ST_OUT
   } state_type;

   function automatic logic [2:0] encode_div(input logic [2:0] d);
      logic [2:0] c;
      unique case (d)
         3'd1:    c = CODE_DIV1;
         3'd2:    c = CODE_DIV2;
         3'd3:    c = CODE_DIV3;
         3'd4:    c = CODE_DIV4;
         3'd5:    c = CODE_DIV5;
         3'd6:    c = CODE_DIV6;
         3'd7:    c = CODE_DIV7;
         default: c = CODE_DIV1;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/ubds_if.sv =====
interface ubds_req_if;
   logic        valid;
   logic        ready;
   logic [27:0] baud_rate;
   modport source (output valid, output baud_rate, input ready);
   modport sink (input valid, input baud_rate, output ready);
endinterface

interface ubds_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [2:0]  refdiv_code;
   logic [15:0] inc_value;
   logic [15:0] mod_value;
   modport source (output valid, output accepted, output refdiv_code,
                   output inc_value, output mod_value, input ready);
   modport sink (input valid, input accepted, input refdiv_code,
                 input inc_value, input mod_value, output ready);
endinterface

// ===== rtl/uart_baud_divisor_solver.sv =====
// UART baud divisor solver.
// Write the reference clock frequency in hertz through csr_we/csr_wdata
// while the block is idle; reset loads 80 MHz.
// Each transfer on the request channel carries a baud rate. The block
// reduces clock : 16*baud by its GCD, scales it into range, picks a
// pre-divider of 1 to 7, rebuilds the achieved rate through a second GCD
// and accepts the settings when the error is below 3 percent. A rejected
// request returns all fields zero.
// Every division, remainder and GCD step runs through one shared
// restoring divider, one quotient bit per cycle.
// When baud or clock is zero the request goes from idle straight to the
// finish and output states; otherwise the time to the result is set by
// the number of GCD steps. After the response transfer the block returns
// to idle. One item is worked on at a time: req_ch.ready is high only
// while idle.
// The result sits in the output register until the response transfer; a
// stalled receiver holds the block with the result, and no new request is
// taken. Reset drops any item in flight and clears the response valid.
module uart_baud_divisor_solver (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata,
   ubds_req_if.sink          req_ch,
   ubds_rsp_if.source        rsp_ch
);
   import ubds_pkg::*;

   state_type          state_ff, state_in;
   logic [31:0]        clk_ff;
   logic [27:0]        baud_ff, baud_in;
   logic [31:0]        ga_ff, ga_in, gb_ff, gb_in;
   logic [31:0]        num_ff, num_in, den_ff, den_in;
   logic [31:0]        mx_ff, mx_in;
   logic [2:0]         divr_ff, divr_in;
   logic [31:0]        tn_ff, tn_in, td_ff, td_in;
   logic [47:0]        prod_ff, prod_in;
   logic [47:0]        ach_ff, ach_in;
   logic [31:0]        tol_ff, tol_in;
   logic [31:0]        modq_ff, modq_in;
   logic               acc_ff, acc_in;
   logic [2:0]         code_ff, code_in;
   logic [15:0]        inc_ff, inc_in, mod_ff, mod_in;

   logic               div_start, div_busy, div_done;
   logic [DivW-1:0]    div_a, div_q;
   logic [DsrW-1:0]    div_b, div_r;
   logic [31:0]        d16, num16, nq1;
   logic [47:0]        diff;

   assign d16   = {baud_ff, 4'b0000};
   assign num16 = {num_ff[27:0], 4'b0000};
   assign nq1   = div_q[31:0] + 32'd1;

   ubds_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   always_comb begin
      state_in  = state_ff;
      baud_in   = baud_ff;
      ga_in     = ga_ff;
      gb_in     = gb_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      mx_in     = mx_ff;
      divr_in   = divr_ff;
      tn_in     = tn_ff;
      td_in     = td_ff;
      prod_in   = prod_ff;
      ach_in    = ach_ff;
      tol_in    = tol_ff;
      modq_in   = modq_ff;
      acc_in    = acc_ff;
      code_in   = code_ff;
      inc_in    = inc_ff;
      mod_in    = mod_ff;
      div_a     = '0;
      div_b     = 32'd1;
      div_start = 1'b0;
      diff      = (ach_ff >= {20'd0, baud_ff}) ? ach_ff - {20'd0, baud_ff}
                                               : {20'd0, baud_ff} - ach_ff;

      unique case (state_ff)
         ST_GCD1, ST_GCD2: begin div_a = {16'd0, ga_ff}; div_b = gb_ff; end
         ST_NUM, ST_TN:    begin div_a = {16'd0, clk_ff}; div_b = ga_ff; end
         ST_DEN:           begin div_a = {16'd0, d16}; div_b = ga_ff; end
         ST_M:             begin div_a = {16'd0, num_ff - 32'd1}; div_b = NUM_MAX; end
         ST_N:             begin div_a = {16'd0, den_ff - 32'd1}; div_b = INC_MAX; end
         ST_SNUM:          begin div_a = {16'd0, num_ff}; div_b = mx_ff; end
         ST_SDEN:          begin div_a = {16'd0, den_ff}; div_b = mx_ff; end
         ST_DIVR:          begin div_a = {16'd0, num_ff - 32'd1}; div_b = INC_MAX; end
         ST_TD:            begin div_a = {16'd0, num16}; div_b = ga_ff; end
         ST_ACH:           begin div_a = prod_ff; div_b = td_ff; end
         ST_TOL:           begin div_a = {20'd0, baud_ff}; div_b = TOL_DIV; end
         ST_MOD:           begin div_a = {16'd0, num_ff}; div_b = {29'd0, divr_ff}; end
         default:          begin div_a = '0; div_b = 32'd1; end
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               baud_in = req_ch.baud_rate;
               ga_in   = clk_ff;
               gb_in   = {req_ch.baud_rate, 4'b0000};
               acc_in  = 1'b0;
               if (req_ch.baud_rate == 28'd0 || clk_ff == 32'd0) begin
                  state_in = ST_FINISH;
                  ach_in   = '0;
                  tol_in   = '0;
               end else begin
                  state_in = ST_GCD1;
               end
            end
         end
         ST_GCD1, ST_GCD2: begin
            if (gb_ff == 32'd0) begin
               state_in = (state_ff == ST_GCD1) ? ST_NUM : ST_TN;
            end else if (div_done) begin
               ga_in = gb_ff;
               gb_in = div_r;
            end else if (!div_busy) begin
               div_start = 1'b1;
            end
         end
         ST_MUL: begin
            prod_in  = 48'(tn_ff) * 48'(den_ff[15:0]);
            state_in = ST_ACH;
         end
         ST_FINISH: begin
            acc_in = (diff < {16'd0, tol_ff});
            if (diff < {16'd0, tol_ff}) begin
               code_in = encode_div(divr_ff);
               inc_in  = 16'(den_ff - 32'd1);
               mod_in  = 16'(modq_ff - 32'd1);
            end else begin
               code_in = '0;
               inc_in  = '0;
               mod_in  = '0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ch.ready) state_in = ST_IDLE;
         end
         default: begin
            if (div_done) begin
               unique case (state_ff)
                  ST_NUM: begin num_in = div_q[31:0]; state_in = ST_DEN; end
                  ST_DEN: begin
                     den_in = div_q[31:0];
                     if (num_ff > NUM_MAX || div_q[31:0] > INC_MAX) state_in = ST_M;
                     else state_in = ST_DIVR;
                  end
                  ST_M:   begin mx_in = nq1; state_in = ST_N; end
                  ST_N: begin
                     if (nq1 > mx_ff) mx_in = nq1;
                     state_in = ST_SNUM;
                  end
                  ST_SNUM: begin
                     num_in   = (div_q[31:0] == 32'd0) ? 32'd1 : div_q[31:0];
                     state_in = ST_SDEN;
                  end
                  ST_SDEN: begin
                     den_in   = (div_q[31:0] == 32'd0) ? 32'd1 : div_q[31:0];
                     state_in = ST_DIVR;
                  end
                  ST_DIVR: begin
                     divr_in  = div_q[2:0] + 3'd1;
                     ga_in    = clk_ff;
                     gb_in    = num16;
                     state_in = ST_GCD2;
                  end
                  ST_TN:  begin tn_in = div_q[31:0]; state_in = ST_TD; end
                  ST_TD:  begin td_in = div_q[31:0]; state_in = ST_MUL; end
                  ST_ACH: begin ach_in = div_q; state_in = ST_TOL; end
                  ST_TOL: begin tol_in = 32'(div_q[31:0] * 32'd3); state_in = ST_MOD; end
                  ST_MOD: begin modq_in = div_q[31:0]; state_in = ST_FINISH; end
                  default: state_in = ST_IDLE;
               endcase
            end else if (!div_busy) begin
               div_start = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         clk_ff   <= CLK_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) clk_ff <= csr_wdata;
      end
      baud_ff <= baud_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      mx_ff   <= mx_in;
      divr_ff <= divr_in;
      tn_ff   <= tn_in;
      td_ff   <= td_in;
      prod_ff <= prod_in;
      ach_ff  <= ach_in;
      tol_ff  <= tol_in;
      modq_ff <= modq_in;
      acc_ff  <= acc_in;
      code_ff <= code_in;
      inc_ff  <= inc_in;
      mod_ff  <= mod_in;
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_OUT);
   assign rsp_ch.accepted    = acc_ff;
   assign rsp_ch.refdiv_code = code_ff;
   assign rsp_ch.inc_value   = inc_ff;
   assign rsp_ch.mod_value   = mod_ff;

endmodule

// ===== rtl/ubds_divider.sv =====
module ubds_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ubds_pkg::DivW-1:0]     dividend,
   input  logic [ubds_pkg::DsrW-1:0]     divisor,
   output logic                          busy,
   output logic                          done,
   output logic [ubds_pkg::DivW-1:0]     quot,
   output logic [ubds_pkg::DsrW-1:0]     rem
);
   import ubds_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [DivW-1:0]     quot_ff, quot_in;
   logic [DsrW-1:0]     rem_ff, rem_in;
   logic [DsrW-1:0]     dsr_ff, dsr_in;
   logic [DsrW:0]       trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quot_ff[DivW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(DivW);
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = DsrW'(trial - {1'b0, dsr_ff});
            quot_in = {quot_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in  = trial[DsrW-1:0];
            quot_in = {quot_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ===== tb/ubds_checker.sv =====
module ubds_checker
   import ubds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   ubds_req_if         req_ch,
   ubds_rsp_if         rsp_ch,
   output int          mismatch_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  refdiv_code;
      logic [15:0] inc_value;
      logic [15:0] mod_value;
   } divisor_type;

   divisor_type expected_divisors[$];
   logic [31:0] ref_clock;

   assign outstanding = expected_divisors.size();

   function automatic logic [63:0] gcd(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] g;
      g = 64'd1;
      while (b != 0) begin
         g = b;
         b = a % b;
         a = g;
      end
      return g;
   endfunction

   function automatic divisor_type solve_divisor(input logic [27:0] baud_in,
                                                 input logic [31:0] clk_in);
      logic [63:0] baud, clk, lim, d16, g, num, den, m, n, mx;
      logic [63:0] divider, g2, tn, td, achieved, diff;
      divisor_type r;
      r = '0;
      baud = 64'(baud_in);
      clk = 64'(clk_in);
      lim = 64'(INC_MAX);
      if (baud == 0 || clk == 0)
         return r;
      d16 = baud << 4;
      g = gcd(clk, d16);
      num = clk / g;
      den = d16 / g;
      // scale into the increment and modulus ranges
      if (num > lim * 7 || den > lim) begin
         m = (num - 1) / (lim * 7) + 1;
         n = (den - 1) / lim + 1;
         mx = (m > n) ? m : n;
         num = num / mx;
         den = den / mx;
         if (num == 0) num = 1;
         if (den == 0) den = 1;
      end
      divider = (num - 1) / lim + 1;
      g2 = gcd(clk, num << 4);
      tn = clk / g2;
      td = (num << 4) / g2;
      achieved = (tn * den) / td;
      diff = (achieved >= baud) ? achieved - baud : baud - achieved;
      if (diff < (baud / 100) * 3) begin
         r.accepted = 1'b1;
         case (divider)
            1:       r.refdiv_code = CODE_DIV1;
            2:       r.refdiv_code = CODE_DIV2;
            3:       r.refdiv_code = CODE_DIV3;
            4:       r.refdiv_code = CODE_DIV4;
            5:       r.refdiv_code = CODE_DIV5;
            6:       r.refdiv_code = CODE_DIV6;
            7:       r.refdiv_code = CODE_DIV7;
            default: r.refdiv_code = CODE_DIV1;
         endcase
         r.inc_value = 16'(den - 1);
         r.mod_value = 16'(num / divider - 1);
      end
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   initial mismatch_count = 0;

   always @(posedge clock) begin
      divisor_type want;
      if (reset) begin
         ref_clock = CLK_RESET;
         expected_divisors.delete();
      end else begin
         if (csr_we)
            ref_clock = csr_wdata;
         if (req_ch.valid && req_ch.ready)
            expected_divisors.push_back(solve_divisor(req_ch.baud_rate, ref_clock));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_divisors.size() == 0) begin
               report("unexpected transfer", 32'd0, 32'd0);
            end else begin
               want = expected_divisors.pop_front();
               if (rsp_ch.accepted !== want.accepted)
                  report("accepted", 32'(rsp_ch.accepted), 32'(want.accepted));
               if (rsp_ch.refdiv_code !== want.refdiv_code)
                  report("refdiv_code", 32'(rsp_ch.refdiv_code), 32'(want.refdiv_code));
               if (rsp_ch.inc_value !== want.inc_value)
                  report("inc_value", 32'(rsp_ch.inc_value), 32'(want.inc_value));
               if (rsp_ch.mod_value !== want.mod_value)
                  report("mod_value", 32'(rsp_ch.mod_value), 32'(want.mod_value));
            end
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import ubds_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 40000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   int          mismatch_count;
   int          outstanding;
   int          quiet_cycles;

   ubds_req_if req_ch();
   ubds_rsp_if rsp_ch();

   uart_baud_divisor_solver dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   ubds_checker checker_i (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_ch(req_ch), .rsp_ch(rsp_ch),
      .mismatch_count(mismatch_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.baud_rate = '0;
      rsp_ch.ready = 1'b0;
   end

   // count cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      quiet_cycles = 0;
      wait (quiet_cycles >= IdleLimit);
      $display("FAILURE");
      $finish;
   end

   // receiver: random stall before each transfer, one long hold-off
   initial begin
      int stall;
      int taken;
      taken = 0;
      @(negedge reset);
      forever begin
         stall = (taken == 30) ? 8000 : $urandom_range(0, 14);
         if ($urandom_range(0, 3) == 0 && taken != 30) stall = 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   task automatic send_baud(input logic [27:0] baud);
      int gap;
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.baud_rate <= baud;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_ref_clock(input logic [31:0] hz);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= hz;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [27:0] random_baud();
      logic [27:0] common_rates[10];
      logic [27:0] b;
      common_rates = '{300, 1200, 2400, 9600, 19200, 38400, 57600, 115200,
                       921600, 3000000};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            b = common_rates[$urandom_range(0, 9)];
            if ($urandom_range(0, 1) == 1) b = b + $urandom_range(0, 50) - 25;
         end
         4, 5, 6: b = $urandom_range(100, 4000000);
         7:       b = $urandom_range(0, 120);
         default: b = 28'($urandom());
      endcase
      return b;
   endfunction

   task automatic random_phase(input logic [31:0] hz, input int count);
      write_ref_clock(hz);
      for (int i = 0; i < count; i++) begin
         // pause until all results are back
         if (i == count / 2) drain();
         send_baud(random_baud());
      end
   endtask

   initial begin
      logic [27:0] directed[$];
      directed = '{28'd0, 28'd1, 28'd99, 28'd100, 28'd101, 28'hFFFFFFF, 28'h8000000,
                   28'd9600, 28'd115200, 28'd921600, 28'd3000000, 28'd5000000,
                   28'd4800, 28'd1843200, 28'h5555555, 28'hAAAAAAA};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_baud(directed[i]);
      random_phase(32'hFFFFFFFF, 25);
      random_phase(32'd1, 8);
      random_phase(32'd0, 5);
      random_phase(32'd48000000, 30);
      random_phase(32'd1843200, 25);
      random_phase(32'd80000000, 40);
      random_phase(32'd24000000, 15);
      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ubds_pkg.sv
rtl/ubds_if.sv
rtl/ubds_divider.sv
rtl/uart_baud_divisor_solver.sv
tb/ubds_checker.sv
tb/testbench.sv
